// ----- hdl/cobs_frame_encoder_top_macros.svh -----
// Assertion helpers for the frame encoder; they expect clock and reset in scope.
`ifndef COBS_FRAME_ENCODER_TOP_MACROS_SVH
`define COBS_FRAME_ENCODER_TOP_MACROS_SVH

`define COBS_ENC_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define COBS_ENC_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/cobs_enc_pkg.sv -----
package cobs_enc_pkg;

   localparam int PAYLOAD_BYTES = 8;
   localparam int BYTE_W        = 8;

   localparam logic [BYTE_W-1:0] FRAME_DELIM = 8'h00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CODE,
      ST_DATA,
      ST_DELIM
   } state_type;

endpackage

// ----- hdl/cobs_enc_ram.sv -----
module cobs_enc_ram #(
   parameter int WIDTH = cobs_enc_pkg::BYTE_W,
   parameter int DEPTH = cobs_enc_pkg::PAYLOAD_BYTES,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/cobs_enc_seq.sv -----
module cobs_enc_seq #(
   parameter int PAYLOAD_BYTES = cobs_enc_pkg::PAYLOAD_BYTES,
   parameter int AW            = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cobs_enc_pkg::BYTE_W-1:0]  req_payload_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cobs_enc_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                             rsp_run_last,
   output logic                             rsp_frame_end,
   output logic                             ram_we,
   output logic [AW-1:0]                    ram_waddr,
   output logic [cobs_enc_pkg::BYTE_W-1:0]  ram_wdata,
   output logic [AW-1:0]                    ram_raddr,
   input  logic [cobs_enc_pkg::BYTE_W-1:0]  ram_rdata
);

   localparam int CW = $clog2(PAYLOAD_BYTES + 1);
   localparam logic [AW-1:0] LAST_POS = AW'(PAYLOAD_BYTES - 1);

   cobs_enc_pkg::state_type state_ff, state_in;

   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] blk_ff, blk_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          extra_ff, extra_in;
   logic          delim_ff, delim_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [cobs_enc_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic          run_last_ff, run_last_in;
   logic          frame_end_ff, frame_end_in;

   logic accept;
   logic slot_free;
   logic is_last;
   logic nonzero;
   logic data_end;
   logic load;

   assign req_ready = (state_ff == cobs_enc_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_last   = (pos_ff == LAST_POS);
   assign nonzero   = (req_payload_byte != cobs_enc_pkg::FRAME_DELIM);
   assign data_end  = (CW'(idx_ff + 1'b1) == blk_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cobs_enc_pkg::ST_IDLE: begin
            if (accept && !(nonzero && !is_last)) begin
               state_in = cobs_enc_pkg::ST_CODE;
            end
         end
         cobs_enc_pkg::ST_CODE: begin
            if (slot_free) begin
               if (blk_ff != '0) begin
                  state_in = cobs_enc_pkg::ST_DATA;
               end else if (extra_ff) begin
                  state_in = cobs_enc_pkg::ST_CODE;
               end else if (delim_ff) begin
                  state_in = cobs_enc_pkg::ST_DELIM;
               end else begin
                  state_in = cobs_enc_pkg::ST_IDLE;
               end
            end
         end
         cobs_enc_pkg::ST_DATA: begin
            if (slot_free && data_end) begin
               if (extra_ff) begin
                  state_in = cobs_enc_pkg::ST_CODE;
               end else if (delim_ff) begin
                  state_in = cobs_enc_pkg::ST_DELIM;
               end else begin
                  state_in = cobs_enc_pkg::ST_IDLE;
               end
            end
         end
         cobs_enc_pkg::ST_DELIM: begin
            if (slot_free) begin
               state_in = cobs_enc_pkg::ST_IDLE;
            end
         end
         default: state_in = cobs_enc_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      blk_in       = blk_ff;
      idx_in       = idx_ff;
      extra_in     = extra_ff;
      delim_in     = delim_ff;
      load         = 1'b0;
      out_byte_in  = out_byte_ff;
      run_last_in  = run_last_ff;
      frame_end_in = frame_end_ff;
      ram_we       = 1'b0;
      case (state_ff)
         cobs_enc_pkg::ST_IDLE: begin
            if (accept) begin
               ram_we   = nonzero;
               pos_in   = is_last ? '0 : AW'(pos_ff + 1'b1);
               cnt_in   = (nonzero && !is_last) ? CW'(cnt_ff + 1'b1) : '0;
               blk_in   = nonzero ? CW'(cnt_ff + 1'b1) : cnt_ff;
               extra_in = !nonzero && is_last;
               delim_in = is_last;
               idx_in   = '0;
            end
         end
         cobs_enc_pkg::ST_CODE: begin
            if (slot_free) begin
               load         = 1'b1;
               out_byte_in  = cobs_enc_pkg::BYTE_W'(blk_ff) + 1'b1;
               run_last_in  = (blk_ff == '0) && !extra_ff && !delim_ff;
               frame_end_in = 1'b0;
               idx_in       = '0;
               if (blk_ff == '0) begin
                  extra_in = 1'b0;
               end
            end
         end
         cobs_enc_pkg::ST_DATA: begin
            if (slot_free) begin
               load         = 1'b1;
               out_byte_in  = ram_rdata;
               run_last_in  = data_end && !extra_ff && !delim_ff;
               frame_end_in = 1'b0;
               idx_in       = CW'(idx_ff + 1'b1);
               if (data_end && extra_ff) begin
                  extra_in = 1'b0;
                  blk_in   = '0;
               end
            end
         end
         cobs_enc_pkg::ST_DELIM: begin
            if (slot_free) begin
               load         = 1'b1;
               out_byte_in  = cobs_enc_pkg::FRAME_DELIM;
               run_last_in  = 1'b1;
               frame_end_in = 1'b1;
               delim_in     = 1'b0;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   assign ram_waddr = cnt_ff[AW-1:0];
   assign ram_wdata = req_payload_byte;
   assign ram_raddr = idx_in[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cobs_enc_pkg::ST_IDLE;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         extra_ff     <= 1'b0;
         delim_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         extra_ff     <= extra_in;
         delim_ff     <= delim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff       <= blk_in;
      idx_ff       <= idx_in;
      out_byte_ff  <= out_byte_in;
      run_last_ff  <= run_last_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

// ----- hdl/cobs_frame_encoder_top.sv -----
// COBS frame encoder for packets of PAYLOAD_BYTES bytes (1 to 254). Each
// request carries one payload byte. Non-zero bytes are written into a block
// buffer RAM and produce no response. A zero byte, or the last byte of a
// packet, closes the open block: the encoder emits a code byte (buffered
// count plus one) and then reads the buffered bytes back out of the RAM, one
// per cycle while no response stalls, and it takes no new request until all
// response bytes of such a request are issued (code, data and, after the last
// byte, a second code byte when it was zero, and the zero delimiter flagged
// by rsp_frame_end). rsp_run_last marks the final response of each request.
// A registered output stage lets the next request in while the last
// response waits for rsp_ready; a stalled response stalls the sequencer.
`include "cobs_frame_encoder_top_macros.svh"

module cobs_frame_encoder_top #(
   parameter int PAYLOAD_BYTES = cobs_enc_pkg::PAYLOAD_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cobs_enc_pkg::BYTE_W-1:0]  req_payload_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cobs_enc_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                             rsp_run_last,
   output logic                             rsp_frame_end
);

   localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

   logic                            ram_we;
   logic [AW-1:0]                   ram_waddr;
   logic [cobs_enc_pkg::BYTE_W-1:0] ram_wdata;
   logic [AW-1:0]                   ram_raddr;
   logic [cobs_enc_pkg::BYTE_W-1:0] ram_rdata;

   cobs_enc_ram #(
      .WIDTH (cobs_enc_pkg::BYTE_W),
      .DEPTH (PAYLOAD_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   cobs_enc_seq #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .AW            (AW)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_end    (rsp_frame_end),
      .ram_we           (ram_we),
      .ram_waddr        (ram_waddr),
      .ram_wdata        (ram_wdata),
      .ram_raddr        (ram_raddr),
      .ram_rdata        (ram_rdata)
   );

   `COBS_ENC_IMPLIES(a_delim_closes_run, rsp_valid && rsp_frame_end, (rsp_out_byte == cobs_enc_pkg::FRAME_DELIM) && rsp_run_last, "delimiter not zero or not last of run")
   `COBS_ENC_IMPLIES(a_write_on_request, ram_we, req_valid && req_ready, "buffer write without request")
   `COBS_ENC_IMPLIES(a_write_nonzero, ram_we, ram_wdata != cobs_enc_pkg::FRAME_DELIM, "zero byte written to buffer")

endmodule
